[sv/iis_pkg.sv]
// Shared widths, register indexes and defaults for the integral image stream core.
package iis_pkg;

  localparam int PIX_W = 8;
  localparam int PIX_MAX = 255;
  localparam int SUM_W = 28;
  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

endpackage

[sv/iis_if.sv]
// Valid/ready stream interfaces for the pixel input and the integral result output.
interface iis_pixel_if;
  import iis_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface iis_result_if;
  import iis_pkg::*;

  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] area_sum;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output area_sum, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input area_sum, input row_end, input frame_end,
                output ready);
endinterface

[sv/integral_image_stream_core.sv]
// Top level of the streaming integral image (summed-area table) core.
// The core accepts one grey pixel per clock in raster order, unless the output stalls, and
// returns one integral value per pixel, with row and frame end flags, from the stage-one and
// output registers; the throughput of one transaction per cycle is held by the line store,
// read when a pixel is accepted and written with its integral value as it leaves stage one;
// a write to the entry being read in that same cycle is forwarded. Output stalls reach the
// input through both registers. The line store needs no clearing: row zero ignores its data.
module integral_image_stream_core #(
  parameter int MAX_WIDTH = iis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  iis_pixel_if.sink                    in_pix,
  iis_result_if.source                 out_res,
  input  logic                         cfg_we,
  input  logic [iis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iis_pkg::CFG_W-1:0]     cfg_data
);
  import iis_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WB_W = $clog2(MAX_WIDTH + 1);
  localparam int HB_W = $clog2(MAX_HEIGHT + 1);
  localparam int MB_W = (WB_W > HB_W) ? WB_W : HB_W;
  localparam int DIM_W = (MB_W > CFG_W) ? MB_W : CFG_W;
  localparam int RS_W = $clog2(MAX_WIDTH * PIX_MAX + 1);

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [RS_W-1:0]  rs_r, rs_nxt;

  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic [RS_W-1:0]  s1_rs_r;
  logic             s1_row0_r;
  logic             s1_row_end_r;
  logic             s1_frame_end_r;
  logic             fwd_r;
  logic [SUM_W-1:0] fwd_data_r;

  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;
  logic             out_row_end_r;
  logic             out_frame_end_r;

  logic [DIM_W-1:0] w_cfg, h_cfg, w_eff, h_eff;
  logic [DIM_W-1:0] col_next_ext, row_next_ext;
  logic             in_accept, s1_adv;
  logic             acc_row_end, acc_frame_end;
  logic [RS_W-1:0]  rs_cur;
  logic [SUM_W-1:0] rd_data, above, s1_sum;
  logic             mem_we;

  assign w_cfg = DIM_W'(width_r);
  assign h_cfg = DIM_W'(height_r);

  always_comb begin
    if (w_cfg == '0) begin
      w_eff = DIM_W'(1);
    end else if (w_cfg > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    if (h_cfg == '0) begin
      h_eff = DIM_W'(1);
    end else if (h_cfg > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_cfg;
    end
  end

  assign s1_adv = !out_valid_r || out_res.ready;
  assign in_pix.ready = !s1_valid_r || s1_adv;
  assign in_accept = in_pix.valid && in_pix.ready;

  assign col_next_ext = DIM_W'(col_r) + DIM_W'(1);
  assign row_next_ext = DIM_W'(row_r) + DIM_W'(1);
  assign acc_row_end = col_next_ext >= w_eff;
  assign acc_frame_end = acc_row_end && (row_next_ext >= h_eff);
  assign rs_cur = ((col_r == '0) ? '0 : rs_r) + RS_W'(in_pix.pixel);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    rs_nxt = rs_r;
    if (in_accept) begin
      if (acc_row_end) begin
        col_nxt = '0;
        rs_nxt = '0;
        row_nxt = acc_frame_end ? '0 : ROW_W'(row_next_ext);
      end else begin
        col_nxt = COL_W'(col_next_ext);
        rs_nxt = rs_cur;
      end
    end
  end

  assign above = s1_row0_r ? '0 : (fwd_r ? fwd_data_r : rd_data);
  assign s1_sum = above + SUM_W'(s1_rs_r);
  assign mem_we = s1_valid_r && s1_adv;

  iis_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_col_r),
    .wdata (s1_sum),
    .re    (in_accept),
    .raddr (col_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= DIM_RESET;
      height_r <= DIM_RESET;
      col_r <= '0;
      row_r <= '0;
      rs_r <= '0;
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: width_r <= cfg_data;
          REG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      rs_r <= rs_nxt;
      if (in_pix.ready) begin
        s1_valid_r <= in_accept;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r <= col_r;
      s1_rs_r <= rs_cur;
      s1_row0_r <= (row_r == '0);
      s1_row_end_r <= acc_row_end;
      s1_frame_end_r <= acc_frame_end;
      fwd_r <= mem_we && (s1_col_r == col_r);
      fwd_data_r <= s1_sum;
    end
    if (mem_we) begin
      out_sum_r <= s1_sum;
      out_row_end_r <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.area_sum = out_sum_r;
  assign out_res.row_end = out_row_end_r;
  assign out_res.frame_end = out_frame_end_r;

  a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end_r |-> out_row_end_r)
    else $error("frame end flagged without row end");

  a_frame_wraps_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && acc_frame_end |=> row_r == '0 && col_r == '0)
    else $error("row or column index not cleared after frame end");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result transaction appeared without a pending pixel");

endmodule

[sv/iis_line_mem.sv]
// Single-port-write, single-port-read line store with a registered read.
module iis_line_mem #(
  parameter int DEPTH = iis_pkg::DEF_MAX_WIDTH,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [iis_pkg::SUM_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [iis_pkg::SUM_W-1:0] rdata
);
  import iis_pkg::*;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
